>>> src/dla_pkg.sv
package dla_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SIZE_W     = 9;
    localparam int COORD_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [1:0] {
        ST_WALKING  = 2'd0,
        ST_STUCK    = 2'd1,
        ST_OCCUPIED = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_MID,
        S_RD_UP,
        S_RD_DN,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic               move_axis;
        logic               move_positive;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
    } t_out;

    // Size in use: zero counts as one, and the size never exceeds the
    // smaller of the array limit and 256.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
        int lim;
        lim = (maxv < 256) ? maxv : 256;
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > SIZE_W'(lim)) begin
            return SIZE_W'(lim);
        end
        return v;
    endfunction

endpackage

>>> src/dla_walker_grid_step.sv
// Each accepted word takes three row reads over the single grid memory port (its
// own row, then the rows on either side), then decide and write once the output
// register is free; a launch outside the grid skips the reads. No new word is
// accepted until the result of the last one is in the output register.
// Reset and every configuration write start a clearing pass over all MAX_HEIGHT
// rows (one grid row per cycle, center cell seeded) during which no word is accepted.
module dla_walker_grid_step #(
    parameter int MAX_WIDTH  = dla_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dla_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  dla_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output dla_pkg::t_out                  o_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int CW = dla_pkg::COORD_W;
    localparam int SW = dla_pkg::SIZE_W;
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_HEIGHT - 1);

    // Grid memory: one row of cells per entry.
    logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] r_rd_data;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_addr;
    logic [MAX_WIDTH-1:0] mem_wdata;

    dla_pkg::t_state      r_state, n_state;
    logic [SW-1:0]        r_grid_w, n_grid_w;
    logic [SW-1:0]        r_grid_h, n_grid_h;
    logic [AW-1:0]        r_clr, n_clr;
    logic                 r_active, n_active;
    logic                 r_launch, n_launch;
    logic                 r_oor, n_oor;
    logic [CW-1:0]        r_x, n_x;
    logic [CW-1:0]        r_y, n_y;
    logic                 r_self, n_self;
    logic                 r_nb, n_nb;
    logic [MAX_WIDTH-1:0] r_mid_row, n_mid_row;
    logic                 r_out_valid, n_out_valid;
    dla_pkg::t_out        r_out, n_out;

    logic [SW-1:0]        w_eff;
    logic [SW-1:0]        h_eff;
    logic [CW-1:0]        cx;
    logic [CW-1:0]        cy;
    logic [SW-1:0]        x_inc;
    logic [SW-1:0]        y_inc;
    logic                 accept;
    logic                 nb_all;
    logic                 stick;
    logic [MAX_WIDTH-1:0] row_set;
    logic [MAX_WIDTH-1:0] seed_row;

    always_comb begin
        w_eff    = dla_pkg::eff_size(r_grid_w, MAX_WIDTH);
        h_eff    = dla_pkg::eff_size(r_grid_h, MAX_HEIGHT);
        cx       = CW'(w_eff >> 1);
        cy       = CW'(h_eff >> 1);
        x_inc    = {1'b0, r_x} + SW'(1);
        y_inc    = {1'b0, r_y} + SW'(1);
        seed_row = '0;
        seed_row[XW'(cx)] = 1'b1;
        row_set  = r_mid_row;
        row_set[XW'(r_x)] = 1'b1;
    end

    assign o_ready = (r_state == dla_pkg::S_IDLE) && !i_cfg_we;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_grid_w    = r_grid_w;
        n_grid_h    = r_grid_h;
        n_clr       = r_clr;
        n_active    = r_active;
        n_launch    = r_launch;
        n_oor       = r_oor;
        n_x         = r_x;
        n_y         = r_y;
        n_self      = r_self;
        n_nb        = r_nb;
        n_mid_row   = r_mid_row;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = AW'(r_y);
        mem_wdata   = row_set;
        nb_all      = r_nb || ((y_inc < h_eff) && r_rd_data[XW'(r_x)]);
        stick       = 1'b0;

        case (r_state)
            dla_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = (r_clr == AW'(cy)) ? seed_row : '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_ROW) begin
                    n_state = dla_pkg::S_IDLE;
                end
            end
            dla_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = dla_pkg::S_RD_MID;
                    if (!r_active) begin
                        n_launch = 1'b1;
                        n_x      = i_data.start_x;
                        n_y      = i_data.start_y;
                        n_oor    = ({1'b0, i_data.start_x} >= w_eff) ||
                                   ({1'b0, i_data.start_y} >= h_eff);
                        if (n_oor) begin
                            n_state = dla_pkg::S_EVAL;
                        end
                    end else begin
                        n_launch = 1'b0;
                        n_oor    = 1'b0;
                        // Moves are clamped at the edges of the grid in use.
                        if (!i_data.move_axis) begin
                            if (i_data.move_positive) begin
                                if (x_inc < w_eff) n_x = r_x + CW'(1);
                            end else if (r_x != '0) begin
                                n_x = r_x - CW'(1);
                            end
                        end else begin
                            if (i_data.move_positive) begin
                                if (y_inc < h_eff) n_y = r_y + CW'(1);
                            end else if (r_y != '0) begin
                                n_y = r_y - CW'(1);
                            end
                        end
                    end
                end
            end
            dla_pkg::S_RD_MID: begin
                mem_re   = 1'b1;
                mem_addr = AW'(r_y);
                n_state  = dla_pkg::S_RD_UP;
            end
            dla_pkg::S_RD_UP: begin
                // Row of the walker is here: own cell and both side neighbors.
                n_mid_row = r_rd_data;
                n_self    = r_rd_data[XW'(r_x)];
                n_nb      = ((r_x != '0) && r_rd_data[XW'(r_x - CW'(1))]) ||
                            ((x_inc < w_eff) && r_rd_data[XW'(r_x + CW'(1))]);
                mem_re    = 1'b1;
                mem_addr  = (r_y != '0) ? AW'(r_y - CW'(1)) : AW'(r_y);
                n_state   = dla_pkg::S_RD_DN;
            end
            dla_pkg::S_RD_DN: begin
                n_nb     = r_nb || ((r_y != '0) && r_rd_data[XW'(r_x)]);
                mem_re   = 1'b1;
                mem_addr = (y_inc < h_eff) ? AW'(r_y + CW'(1)) : AW'(r_y);
                n_state  = dla_pkg::S_EVAL;
            end
            dla_pkg::S_EVAL: begin
                // Hold here until the output register is free; nothing changes
                // meanwhile, since the read data stays put without a read.
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out.pos_x  = r_x;
                    n_out.pos_y  = r_y;
                    n_state      = dla_pkg::S_IDLE;
                    if (r_launch && r_oor) begin
                        n_out.status = dla_pkg::ST_RANGE;
                    end else if (r_launch && r_self) begin
                        n_out.status = dla_pkg::ST_OCCUPIED;
                    end else if (nb_all) begin
                        stick        = 1'b1;
                        n_active     = 1'b0;
                        n_out.status = dla_pkg::ST_STUCK;
                    end else begin
                        n_active     = 1'b1;
                        n_out.status = dla_pkg::ST_WALKING;
                    end
                    if (stick) begin
                        mem_we    = 1'b1;
                        mem_addr  = AW'(r_y);
                        mem_wdata = row_set;
                    end
                end
            end
            default: begin
                n_state = dla_pkg::S_CLEAR;
                n_clr   = '0;
            end
        endcase

        // Any configuration write starts a new run.
        if (i_cfg_we) begin
            if (i_cfg_idx == dla_pkg::CFG_GRID_WIDTH) begin
                n_grid_w = i_cfg_data;
            end else if (i_cfg_idx == dla_pkg::CFG_GRID_HEIGHT) begin
                n_grid_h = i_cfg_data;
            end
            n_state  = dla_pkg::S_CLEAR;
            n_clr    = '0;
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dla_pkg::S_CLEAR;
            r_grid_w    <= dla_pkg::SIZE_RESET;
            r_grid_h    <= dla_pkg::SIZE_RESET;
            r_clr       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grid_w    <= n_grid_w;
            r_grid_h    <= n_grid_h;
            r_clr       <= n_clr;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_launch  <= n_launch;
        r_oor     <= n_oor;
        r_x       <= n_x;
        r_y       <= n_y;
        r_self    <= n_self;
        r_nb      <= n_nb;
        r_mid_row <= n_mid_row;
        r_out     <= n_out;
    end

endmodule
